// ===== rtl/terminal_escape_utf8_parser_macros.svh =====
// Assertion macros shared by the terminal escape and UTF-8 parser modules.
`ifndef TERMINAL_ESCAPE_UTF8_PARSER_MACROS_SVH
`define TERMINAL_ESCAPE_UTF8_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define TEP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TEP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define TEP_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg)
`define TEP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== rtl/tep_pkg.sv =====
// Shared types, codes and defaults for the terminal escape and UTF-8 parser.
`default_nettype none

package tep_pkg;

    localparam int TEP_PARAM_SLOTS = 16;
    localparam int TEP_PARAM_WIDTH = 16;

    localparam int KIND_W  = 2;
    localparam int VALUE_W = 21;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_TEXT  = 2'd0;
    localparam kind_t KIND_ESC   = 2'd1;
    localparam kind_t KIND_PARAM = 2'd2;
    localparam kind_t KIND_FINAL = 2'd3;

    // Source of the next result loaded into the output register.
    typedef logic [1:0] out_sel_t;

    localparam out_sel_t SEL_IMM   = 2'd0;
    localparam out_sel_t SEL_PEND  = 2'd1;
    localparam out_sel_t SEL_PARAM = 2'd2;
    localparam out_sel_t SEL_FINAL = 2'd3;

    typedef struct packed {
        logic     accept;
        logic     load;
        out_sel_t sel;
        logic     rd_en;
    } cmd_t;

    typedef struct packed {
        logic imm_valid;
        logic replay;
        logic csi_dump;
        logic param_last;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/tep_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tep_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== rtl/tep_dp.sv =====
// Datapath: parse state, UTF-8 decoding, CSI parameter store and output register.
`default_nettype none

module tep_dp #(
    parameter int PARAM_SLOTS = tep_pkg::TEP_PARAM_SLOTS,
    parameter int PARAM_WIDTH = tep_pkg::TEP_PARAM_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  tep_pkg::cmd_t                      cmd,
    input  logic [$clog2(PARAM_SLOTS)-1:0]     out_idx,
    input  logic [$clog2(PARAM_SLOTS)-1:0]     rd_idx,
    input  logic [7:0]                         in_byte,
    output tep_pkg::status_t                   status,
    output logic [tep_pkg::KIND_W-1:0]         kind,
    output logic [tep_pkg::VALUE_W-1:0]        value,
    output logic [$clog2(PARAM_SLOTS)-1:0]     param_index,
    output logic                               private_mode,
    output logic [$clog2(PARAM_SLOTS+1)-1:0]   param_count,
    output logic                               last
);

    import tep_pkg::*;

    localparam int IDX_W  = $clog2(PARAM_SLOTS);
    localparam int CNT_W  = $clog2(PARAM_SLOTS + 1);
    localparam int PROD_W = PARAM_WIDTH + 4;

    localparam logic [2:0] M_GROUND  = 3'd0;
    localparam logic [2:0] M_ESCAPE  = 3'd1;
    localparam logic [2:0] M_CSI     = 3'd2;
    localparam logic [2:0] M_OSC     = 3'd3;
    localparam logic [2:0] M_OSC_ESC = 3'd4;
    localparam logic [2:0] M_SKIP    = 3'd5;

    localparam logic [7:0] B_BEL       = 8'h07;
    localparam logic [7:0] B_ESC       = 8'h1B;
    localparam logic [7:0] B_LBRACK    = 8'h5B;
    localparam logic [7:0] B_RBRACK    = 8'h5D;
    localparam logic [7:0] B_BSLASH    = 8'h5C;
    localparam logic [7:0] B_DECSC     = 8'h37;
    localparam logic [7:0] B_DECRC     = 8'h38;
    localparam logic [7:0] B_RIS       = 8'h63;
    localparam logic [7:0] B_NEL       = 8'h45;
    localparam logic [7:0] B_IND       = 8'h44;
    localparam logic [7:0] B_RI        = 8'h4D;
    localparam logic [7:0] B_SCS_G0    = 8'h28;
    localparam logic [7:0] B_SCS_G1    = 8'h29;
    localparam logic [7:0] B_SCS_G2    = 8'h2A;
    localparam logic [7:0] B_SCS_G3    = 8'h2B;
    localparam logic [7:0] B_SCS_G1_96 = 8'h2D;
    localparam logic [7:0] B_SCS_G2_96 = 8'h2E;
    localparam logic [7:0] B_SCS_G3_96 = 8'h2F;
    localparam logic [7:0] B_DEC_LINE  = 8'h23;
    localparam logic [7:0] B_CS_SELECT = 8'h25;
    localparam logic [7:0] B_ZERO      = 8'h30;
    localparam logic [7:0] B_NINE      = 8'h39;
    localparam logic [7:0] B_SEMI      = 8'h3B;
    localparam logic [7:0] B_COLON     = 8'h3A;
    localparam logic [7:0] B_QUEST     = 8'h3F;
    localparam logic [7:0] B_GT        = 8'h3E;

    localparam logic [VALUE_W-1:0] CP_REPLACE = 21'h00FFFD;
    localparam logic [VALUE_W-1:0] CP_MAX     = 21'h10FFFF;
    localparam logic [VALUE_W-1:0] CP_SURR_LO = 21'h00D800;
    localparam logic [VALUE_W-1:0] CP_SURR_HI = 21'h00DFFF;
    localparam logic [VALUE_W-1:0] CP_MIN_2   = 21'h000080;
    localparam logic [VALUE_W-1:0] CP_MIN_3   = 21'h000800;
    localparam logic [VALUE_W-1:0] CP_MIN_4   = 21'h010000;

    typedef struct packed {
        logic               emit;
        logic [VALUE_W-1:0] value;
        logic [VALUE_W-1:0] acc;
        logic [1:0]         cls;
        logic [1:0]         rem;
    } lead_t;

    // A byte seen where a new UTF-8 sequence may start.
    function automatic lead_t lead_decode(input logic [7:0] b);
        lead_t r;
        r = '0;
        if (b < 8'h80) begin
            r.emit  = 1'b1;
            r.value = {13'd0, b};
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            r.acc = {16'd0, b[4:0]};
            r.cls = 2'd1;
            r.rem = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            r.acc = {17'd0, b[3:0]};
            r.cls = 2'd2;
            r.rem = 2'd2;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            r.acc = {18'd0, b[2:0]};
            r.cls = 2'd3;
            r.rem = 2'd3;
        end else begin
            r.emit  = 1'b1;
            r.value = CP_REPLACE;
        end
        return r;
    endfunction

    // Parse state.
    logic [2:0]             mode_reg, mode_next;
    logic [VALUE_W-1:0]     acc_reg, acc_next;
    logic [1:0]             class_reg, class_next;
    logic [1:0]             rem_reg, rem_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [PARAM_WIDTH-1:0] digit_reg, digit_next;
    logic                   seen_reg, seen_next;
    logic                   priv_reg, priv_next;
    logic [VALUE_W-1:0]     pend_reg, pend_next;
    logic [7:0]             final_reg, final_next;

    // Output register payload.
    logic [KIND_W-1:0]      kind_reg;
    logic [VALUE_W-1:0]     value_reg;
    logic [IDX_W-1:0]       index_reg;
    logic                   priv_out_reg;
    logic [CNT_W-1:0]       count_reg;
    logic                   last_reg;

    lead_t                  lead;
    logic [VALUE_W-1:0]     cont_acc;
    logic [VALUE_W-1:0]     cp_min;
    logic                   cp_bad;
    logic [PROD_W-1:0]      digit_prod;
    logic [PARAM_WIDTH-1:0] digit_sat;
    logic [PARAM_WIDTH-1:0] finish_val;
    logic                   room;
    logic                   wr_dec;
    logic                   imm_valid;
    logic                   replay;
    logic                   csi_dump;
    kind_t                  imm_kind;
    logic [VALUE_W-1:0]     imm_value;
    logic [PARAM_WIDTH-1:0] rd_data;

    assign lead     = lead_decode(in_byte);
    assign cont_acc = {acc_reg[VALUE_W-7:0], in_byte[5:0]};

    always_comb begin
        unique case (class_reg)
            2'd1:    cp_min = CP_MIN_2;
            2'd2:    cp_min = CP_MIN_3;
            default: cp_min = CP_MIN_4;
        endcase
    end

    assign cp_bad = (cont_acc < cp_min) || (cont_acc > CP_MAX)
                    || (cont_acc >= CP_SURR_LO && cont_acc <= CP_SURR_HI);

    // Decimal digits are the low nibble of the ASCII code.
    assign digit_prod = PROD_W'(digit_reg) * PROD_W'(10) + PROD_W'(in_byte[3:0]);
    assign digit_sat  = (|digit_prod[PROD_W-1:PARAM_WIDTH]) ? '1
                                                            : digit_prod[PARAM_WIDTH-1:0];
    assign finish_val = seen_reg ? digit_reg : '0;
    assign room       = total_reg < CNT_W'(PARAM_SLOTS);

    // Next state as if the presented byte were taken; registers follow only on accept.
    always_comb begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        class_next = class_reg;
        rem_next   = rem_reg;
        total_next = total_reg;
        digit_next = digit_reg;
        seen_next  = seen_reg;
        priv_next  = priv_reg;
        pend_next  = pend_reg;
        final_next = final_reg;
        wr_dec     = 1'b0;
        imm_valid  = 1'b0;
        imm_kind   = KIND_TEXT;
        imm_value  = '0;
        replay     = 1'b0;
        csi_dump   = 1'b0;

        unique case (mode_reg)
            M_ESCAPE: begin
                mode_next = M_GROUND;
                unique case (in_byte) inside
                    B_LBRACK: begin
                        mode_next  = M_CSI;
                        total_next = '0;
                        digit_next = '0;
                        seen_next  = 1'b0;
                        priv_next  = 1'b0;
                    end
                    B_RBRACK: begin
                        mode_next = M_OSC;
                    end
                    B_RIS: begin
                        acc_next   = '0;
                        class_next = 2'd0;
                        rem_next   = 2'd0;
                        imm_valid  = 1'b1;
                        imm_kind   = KIND_ESC;
                        imm_value  = {13'd0, in_byte};
                    end
                    B_DECSC, B_DECRC, B_NEL, B_IND, B_RI: begin
                        imm_valid = 1'b1;
                        imm_kind  = KIND_ESC;
                        imm_value = {13'd0, in_byte};
                    end
                    B_SCS_G0, B_SCS_G1, B_SCS_G2, B_SCS_G3, B_SCS_G1_96,
                    B_SCS_G2_96, B_SCS_G3_96, B_DEC_LINE, B_CS_SELECT: begin
                        mode_next = M_SKIP;
                    end
                    default: begin
                        mode_next = M_GROUND;
                    end
                endcase
            end
            M_CSI: begin
                if (in_byte >= B_ZERO && in_byte <= B_NINE) begin
                    digit_next = digit_sat;
                    seen_next  = 1'b1;
                end else if (in_byte == B_SEMI || in_byte == B_COLON) begin
                    wr_dec     = room;
                    total_next = room ? total_reg + CNT_W'(1) : total_reg;
                    digit_next = '0;
                    seen_next  = 1'b0;
                end else if (in_byte == B_QUEST && total_reg == '0 && !seen_reg) begin
                    priv_next = 1'b1;
                end else if (in_byte == B_GT) begin
                    mode_next = M_CSI;
                end else begin
                    // Final byte: close an open or empty parameter, then dump the store.
                    if (seen_reg || total_reg == '0) begin
                        wr_dec     = room;
                        total_next = room ? total_reg + CNT_W'(1) : total_reg;
                    end
                    digit_next = '0;
                    seen_next  = 1'b0;
                    final_next = in_byte;
                    csi_dump   = 1'b1;
                    mode_next  = M_GROUND;
                end
            end
            M_OSC: begin
                if (in_byte == B_BEL) begin
                    mode_next = M_GROUND;
                end else if (in_byte == B_ESC) begin
                    mode_next = M_OSC_ESC;
                end
            end
            M_OSC_ESC: begin
                mode_next = (in_byte == B_BSLASH) ? M_GROUND : M_OSC;
            end
            M_SKIP: begin
                mode_next = M_GROUND;
            end
            default: begin
                mode_next = M_GROUND;
                if (in_byte == B_ESC) begin
                    mode_next = M_ESCAPE;
                    if (rem_reg != 2'd0) begin
                        acc_next   = '0;
                        class_next = 2'd0;
                        rem_next   = 2'd0;
                        imm_valid  = 1'b1;
                        imm_value  = CP_REPLACE;
                    end
                end else if (rem_reg == 2'd0) begin
                    acc_next   = lead.acc;
                    class_next = lead.cls;
                    rem_next   = lead.rem;
                    imm_valid  = lead.emit;
                    imm_value  = lead.value;
                end else if (in_byte[7:6] != 2'b10) begin
                    // Broken sequence: replace it, then treat this byte as a fresh lead.
                    acc_next   = lead.acc;
                    class_next = lead.cls;
                    rem_next   = lead.rem;
                    imm_valid  = 1'b1;
                    imm_value  = CP_REPLACE;
                    replay     = lead.emit;
                    pend_next  = lead.value;
                end else if (rem_reg == 2'd1) begin
                    acc_next   = '0;
                    class_next = 2'd0;
                    rem_next   = 2'd0;
                    imm_valid  = 1'b1;
                    imm_value  = cp_bad ? CP_REPLACE : cont_acc;
                end else begin
                    acc_next = cont_acc;
                    rem_next = rem_reg - 2'd1;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_GROUND;
            acc_reg   <= '0;
            class_reg <= 2'd0;
            rem_reg   <= 2'd0;
            total_reg <= '0;
            digit_reg <= '0;
            seen_reg  <= 1'b0;
            priv_reg  <= 1'b0;
        end else if (cmd.accept) begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            class_reg <= class_next;
            rem_reg   <= rem_next;
            total_reg <= total_next;
            digit_reg <= digit_next;
            seen_reg  <= seen_next;
            priv_reg  <= priv_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            pend_reg  <= pend_next;
            final_reg <= final_next;
        end
    end

    tep_ram #(
        .WIDTH (PARAM_WIDTH),
        .DEPTH (PARAM_SLOTS)
    ) u_param_ram (
        .aclk    (aclk),
        .wr_en   (cmd.accept && wr_dec),
        .wr_addr (total_reg[IDX_W-1:0]),
        .wr_data (finish_val),
        .rd_en   (cmd.rd_en),
        .rd_addr (rd_idx),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            unique case (cmd.sel)
                SEL_IMM: begin
                    kind_reg     <= imm_kind;
                    value_reg    <= imm_value;
                    index_reg    <= '0;
                    priv_out_reg <= 1'b0;
                    count_reg    <= '0;
                    last_reg     <= !replay;
                end
                SEL_PEND: begin
                    kind_reg     <= KIND_TEXT;
                    value_reg    <= pend_reg;
                    index_reg    <= '0;
                    priv_out_reg <= 1'b0;
                    count_reg    <= '0;
                    last_reg     <= 1'b1;
                end
                SEL_PARAM: begin
                    kind_reg     <= KIND_PARAM;
                    value_reg    <= VALUE_W'(rd_data);
                    index_reg    <= out_idx;
                    priv_out_reg <= priv_reg;
                    count_reg    <= total_reg;
                    last_reg     <= 1'b0;
                end
                SEL_FINAL: begin
                    kind_reg     <= KIND_FINAL;
                    value_reg    <= {13'd0, final_reg};
                    index_reg    <= '0;
                    priv_out_reg <= priv_reg;
                    count_reg    <= total_reg;
                    last_reg     <= 1'b1;
                end
            endcase
        end
    end

    assign status.imm_valid  = imm_valid;
    assign status.replay     = replay;
    assign status.csi_dump   = csi_dump;
    assign status.param_last = (CNT_W'(out_idx) + CNT_W'(1)) == total_reg;

    assign kind         = kind_reg;
    assign value        = value_reg;
    assign param_index  = index_reg;
    assign private_mode = priv_out_reg;
    assign param_count  = count_reg;
    assign last         = last_reg;

`include "terminal_escape_utf8_parser_macros.svh"

    `TEP_ASSERT_SAME(a_utf8_idle_clear, aclk, aresetn, rem_reg == 2'd0, acc_reg == '0 && class_reg == 2'd0, "UTF-8 state not clear while no sequence is open")
    `TEP_ASSERT_SAME(a_param_nonempty, aclk, aresetn, cmd.load && cmd.sel == SEL_PARAM, total_reg != '0, "Parameter emitted from an empty store")
    `TEP_ASSERT_NEXT(a_dump_has_param, aclk, aresetn, cmd.accept && status.csi_dump, total_reg != '0, "CSI final byte left no parameter")

endmodule

`default_nettype wire

// ===== rtl/tep_ctrl.sv =====
// Controller: handshakes, output valid and the CSI parameter emission sequence.
`default_nettype none

module tep_ctrl #(
    parameter int PARAM_SLOTS = tep_pkg::TEP_PARAM_SLOTS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    output logic                           m_valid,
    input  logic                           m_ready,
    input  tep_pkg::status_t               status,
    output tep_pkg::cmd_t                  cmd,
    output logic [$clog2(PARAM_SLOTS)-1:0] out_idx,
    output logic [$clog2(PARAM_SLOTS)-1:0] rd_idx
);

    import tep_pkg::*;

    localparam int IDX_W = $clog2(PARAM_SLOTS);

    localparam logic [2:0] ST_RUN    = 3'd0;
    localparam logic [2:0] ST_REPLAY = 3'd1;
    localparam logic [2:0] ST_FETCH  = 3'd2;
    localparam logic [2:0] ST_PARAM  = 3'd3;
    localparam logic [2:0] ST_FINAL  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    // The output register can take a new transaction when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        rd_idx     = idx_reg;
        s_ready    = 1'b0;

        unique case (state_reg)
            ST_RUN: begin
                s_ready = out_free;
                if (s_valid && out_free) begin
                    cmd.accept = 1'b1;
                    if (status.imm_valid) begin
                        cmd.load = 1'b1;
                        cmd.sel  = SEL_IMM;
                    end
                    if (status.replay) begin
                        state_next = ST_REPLAY;
                    end else if (status.csi_dump) begin
                        state_next = ST_FETCH;
                        idx_next   = '0;
                    end
                end
            end
            ST_REPLAY: begin
                if (out_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_PEND;
                    state_next = ST_RUN;
                end
            end
            ST_FETCH: begin
                cmd.rd_en  = 1'b1;
                state_next = ST_PARAM;
            end
            ST_PARAM: begin
                if (out_free) begin
                    cmd.load = 1'b1;
                    cmd.sel  = SEL_PARAM;
                    if (status.param_last) begin
                        state_next = ST_FINAL;
                    end else begin
                        // Fetch the following entry while this one goes out.
                        cmd.rd_en = 1'b1;
                        rd_idx    = idx_reg + IDX_W'(1);
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_FINAL: begin
                if (out_free) begin
                    cmd.load   = 1'b1;
                    cmd.sel    = SEL_FINAL;
                    state_next = ST_RUN;
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        m_valid_next = cmd.load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_RUN;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign out_idx = idx_reg;

`include "terminal_escape_utf8_parser_macros.svh"

    `TEP_ASSERT_NEXT(a_fetch_to_param, aclk, aresetn, state_reg == ST_FETCH, state_reg == ST_PARAM, "Parameter fetch not followed by emission")
    `TEP_ASSERT_NEXT(a_replay_entry, aclk, aresetn, s_valid && s_ready && status.replay, state_reg == ST_REPLAY && m_valid_reg, "Replaced byte did not queue its second result")
    `TEP_ASSERT_NEXT(a_final_done, aclk, aresetn, state_reg == ST_FINAL && out_free, state_reg == ST_RUN && m_valid_reg, "CSI final result not loaded")

endmodule

`default_nettype wire

// ===== rtl/terminal_escape_utf8_parser.sv =====
// Top level of the terminal output-stream parser: UTF-8 decoding and escape parsing.
`default_nettype none

// Takes one raw terminal byte per transaction on s_ and returns decoded results on m_.
// Text, escape, OSC and ordinary CSI bytes are taken at one per cycle unless the output
// stalls, with one result register between the two sides. A byte that breaks a UTF-8
// sequence and yields its own result holds the next byte until its second result is
// loaded. A CSI final byte holds the next byte through a fetch state for the first entry,
// the stored parameters at one per cycle unless stalled, through the single read port of
// the parameter RAM, and the final result. The final result of each byte carries last.

module terminal_escape_utf8_parser #(
    parameter int PARAM_SLOTS = tep_pkg::TEP_PARAM_SLOTS,
    parameter int PARAM_WIDTH = tep_pkg::TEP_PARAM_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_in_byte,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [tep_pkg::KIND_W-1:0]         m_kind,
    output logic [tep_pkg::VALUE_W-1:0]        m_value,
    output logic [$clog2(PARAM_SLOTS)-1:0]     m_param_index,
    output logic                               m_private_mode,
    output logic [$clog2(PARAM_SLOTS+1)-1:0]   m_param_count,
    output logic                               m_last
);

    import tep_pkg::*;

    localparam int IDX_W = $clog2(PARAM_SLOTS);

    cmd_t             cmd;
    status_t          status;
    logic [IDX_W-1:0] out_idx;
    logic [IDX_W-1:0] rd_idx;

    tep_ctrl #(
        .PARAM_SLOTS (PARAM_SLOTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd),
        .out_idx (out_idx),
        .rd_idx  (rd_idx)
    );

    tep_dp #(
        .PARAM_SLOTS (PARAM_SLOTS),
        .PARAM_WIDTH (PARAM_WIDTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .out_idx      (out_idx),
        .rd_idx       (rd_idx),
        .in_byte      (s_in_byte),
        .status       (status),
        .kind         (m_kind),
        .value        (m_value),
        .param_index  (m_param_index),
        .private_mode (m_private_mode),
        .param_count  (m_param_count),
        .last         (m_last)
    );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the terminal escape and UTF-8 parser, with a built-in decoder model.
`timescale 1ns / 1ps

module testbench;
    import tep_pkg::*;

    localparam int HALF_PERIOD_NS = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int RANDOM_ITEMS   = 250;
    localparam int SETTLE_CYCLES  = 40;
    localparam int REPORT_LIMIT   = 10;
    localparam int TIMEOUT_NS     = 5_000_000;
    localparam int MAX_PER_BYTE   = 18;

    localparam logic [20:0] REPLACEMENT = 21'h00FFFD;

    // Control and punctuation bytes that steer the parser.
    localparam logic [7:0] CH_BEL = 8'h07, CH_ESC = 8'h1B, CH_CSI = 8'h5B, CH_OSC = 8'h5D,
                           CH_BACKSLASH = 8'h5C, CH_SEMI = 8'h3B, CH_COLON = 8'h3A,
                           CH_QMARK = 8'h3F, CH_GT = 8'h3E, CH_DIGIT0 = 8'h30,
                           CH_DIGIT9 = 8'h39;
    // Escape commands.
    localparam logic [7:0] CH_SAVE = 8'h37, CH_RESTORE = 8'h38, CH_RIS = 8'h63,
                           CH_NEL = 8'h45, CH_IND = 8'h44, CH_RI = 8'h4D;
    // Charset designators, each followed by one byte that is skipped.
    localparam logic [7:0] CH_G0 = 8'h28, CH_G1 = 8'h29, CH_G2 = 8'h2A, CH_G3 = 8'h2B,
                           CH_G1_96 = 8'h2D, CH_G2_96 = 8'h2E, CH_G3_96 = 8'h2F,
                           CH_DEC_LINE = 8'h23, CH_CODING = 8'h25;

    typedef enum logic [2:0] {
        MODE_GROUND, MODE_ESCAPE, MODE_CSI, MODE_OSC, MODE_OSC_ESC, MODE_SKIP
    } parse_mode_t;

    typedef struct packed {
        kind_t       kind;
        logic [20:0] value;
        logic [3:0]  param_index;
        logic        priv;
        logic [4:0]  count;
        logic        last;
    } parser_result_t;

    typedef struct {
        logic [7:0] data;
        bit         drain;
    } stim_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_valid   = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        m_valid;
    logic        m_ready   = 1'b0;
    logic [1:0]  m_kind;
    logic [20:0] m_value;
    logic [3:0]  m_param_index;
    logic        m_private_mode;
    logic [4:0]  m_param_count;
    logic        m_last;

    terminal_escape_utf8_parser u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_value        (m_value),
        .m_param_index  (m_param_index),
        .m_private_mode (m_private_mode),
        .m_param_count  (m_param_count),
        .m_last         (m_last)
    );

    always #HALF_PERIOD_NS aclk = ~aclk;

    stim_byte_t     byte_queue[$];
    parser_result_t due_results[$];
    parser_result_t step_res[MAX_PER_BYTE];
    int             step_n;
    bit             drain_next = 1'b0;
    int             items_sent = 0;
    int             results_seen = 0;
    int             fail_count = 0;

    // Decoder state.
    parse_mode_t mode = MODE_GROUND;
    logic [20:0] utf8_acc = '0;
    logic [1:0]  utf8_class = '0;
    logic [1:0]  utf8_left = '0;
    logic [15:0] param_store[16];
    logic [4:0]  param_total = '0;
    logic [15:0] digit_acc = '0;
    logic        digits_seen = 1'b0;
    logic        priv_flag = 1'b0;

    task automatic add_result(input kind_t kind, input logic [20:0] value,
                              input logic [3:0] idx, input logic priv, input logic [4:0] count);
        step_res[step_n] = '{kind, value, idx, priv, count, 1'b0};
        step_n++;
    endtask

    task automatic clear_utf8();
        utf8_acc   = '0;
        utf8_class = '0;
        utf8_left  = '0;
    endtask

    task automatic clear_csi();
        param_total = '0;
        digit_acc   = '0;
        digits_seen = 1'b0;
        priv_flag   = 1'b0;
    endtask

    task automatic close_param();
        if (param_total < 5'd16) begin
            param_store[param_total[3:0]] = digits_seen ? digit_acc : 16'd0;
            param_total++;
        end
        digit_acc   = '0;
        digits_seen = 1'b0;
    endtask

    task automatic decode_lead(input logic [7:0] b);
        if (b < 8'h80) begin
            add_result(KIND_TEXT, {13'd0, b}, 4'd0, 1'b0, 5'd0);
        end else if (b >= 8'hC2 && b <= 8'hDF) begin
            utf8_acc   = {16'd0, b[4:0]};
            utf8_class = 2'd1;
            utf8_left  = 2'd1;
        end else if (b >= 8'hE0 && b <= 8'hEF) begin
            utf8_acc   = {17'd0, b[3:0]};
            utf8_class = 2'd2;
            utf8_left  = 2'd2;
        end else if (b >= 8'hF0 && b <= 8'hF4) begin
            utf8_acc   = {18'd0, b[2:0]};
            utf8_class = 2'd3;
            utf8_left  = 2'd3;
        end else begin
            add_result(KIND_TEXT, REPLACEMENT, 4'd0, 1'b0, 5'd0);
        end
    endtask

    // Works out every result that one accepted byte causes and queues them in order.
    task automatic decode_byte(input logic [7:0] b);
        logic [31:0] cp;
        logic [31:0] minimum;
        logic [31:0] dval;
        int i;
        step_n = 0;
        case (mode)
            MODE_ESCAPE: begin
                mode = MODE_GROUND;
                case (b)
                    CH_CSI: begin
                        clear_csi();
                        mode = MODE_CSI;
                    end
                    CH_OSC: mode = MODE_OSC;
                    CH_RIS: begin
                        clear_utf8();
                        add_result(KIND_ESC, {13'd0, b}, 4'd0, 1'b0, 5'd0);
                    end
                    CH_SAVE, CH_RESTORE, CH_NEL, CH_IND, CH_RI:
                        add_result(KIND_ESC, {13'd0, b}, 4'd0, 1'b0, 5'd0);
                    CH_G0, CH_G1, CH_G2, CH_G3, CH_G1_96, CH_G2_96, CH_G3_96,
                    CH_DEC_LINE, CH_CODING:
                        mode = MODE_SKIP;
                    default: ;
                endcase
            end
            MODE_CSI: begin
                if (b >= CH_DIGIT0 && b <= CH_DIGIT9) begin
                    dval = {16'd0, digit_acc} * 32'd10 + {24'd0, b - CH_DIGIT0};
                    digit_acc = (dval > 32'hFFFF) ? 16'hFFFF : dval[15:0];
                    digits_seen = 1'b1;
                end else if (b == CH_SEMI || b == CH_COLON) begin
                    close_param();
                end else if (b == CH_QMARK && param_total == 5'd0 && !digits_seen) begin
                    priv_flag = 1'b1;
                end else if (b != CH_GT) begin
                    if (digits_seen || param_total == 5'd0) close_param();
                    for (i = 0; i < param_total; i++) begin
                        add_result(KIND_PARAM, {5'd0, param_store[i]}, 4'(i), priv_flag,
                                   param_total);
                    end
                    add_result(KIND_FINAL, {13'd0, b}, 4'd0, priv_flag, param_total);
                    clear_csi();
                    mode = MODE_GROUND;
                end
            end
            MODE_OSC: begin
                if (b == CH_BEL) mode = MODE_GROUND;
                else if (b == CH_ESC) mode = MODE_OSC_ESC;
            end
            MODE_OSC_ESC: mode = (b == CH_BACKSLASH) ? MODE_GROUND : MODE_OSC;
            MODE_SKIP: mode = MODE_GROUND;
            default: begin
                mode = MODE_GROUND;
                if (b == CH_ESC) begin
                    if (utf8_left != 2'd0) begin
                        clear_utf8();
                        add_result(KIND_TEXT, REPLACEMENT, 4'd0, 1'b0, 5'd0);
                    end
                    mode = MODE_ESCAPE;
                end else if (utf8_left == 2'd0) begin
                    decode_lead(b);
                end else if (b[7:6] != 2'b10) begin
                    // The broken sequence is replaced and the byte starts afresh.
                    clear_utf8();
                    add_result(KIND_TEXT, REPLACEMENT, 4'd0, 1'b0, 5'd0);
                    decode_lead(b);
                end else begin
                    utf8_acc = {utf8_acc[14:0], b[5:0]};
                    utf8_left--;
                    if (utf8_left == 2'd0) begin
                        cp = {11'd0, utf8_acc};
                        case (utf8_class)
                            2'd1:    minimum = 32'h80;
                            2'd2:    minimum = 32'h800;
                            default: minimum = 32'h10000;
                        endcase
                        clear_utf8();
                        if (cp < minimum || cp > 32'h10FFFF || (cp >= 32'hD800 && cp <= 32'hDFFF))
                            add_result(KIND_TEXT, REPLACEMENT, 4'd0, 1'b0, 5'd0);
                        else
                            add_result(KIND_TEXT, cp[20:0], 4'd0, 1'b0, 5'd0);
                    end
                end
            end
        endcase
        for (i = 0; i < step_n; i++) begin
            if (i == step_n - 1) step_res[i].last = 1'b1;
            due_results.push_back(step_res[i]);
        end
    endtask

    task automatic note_error(input string why, input parser_result_t want,
                              input parser_result_t got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %0s: expected kind=%0d value=%h idx=%0d priv=%0d count=%0d last=%0d",
                     $realtime, why, want.kind, want.value, want.param_index, want.priv,
                     want.count, want.last);
            $display("    got kind=%0d value=%h idx=%0d priv=%0d count=%0d last=%0d",
                     got.kind, got.value, got.param_index, got.priv, got.count, got.last);
        end
    endtask

    task automatic add_byte(input logic [7:0] data);
        byte_queue.push_back('{data, drain_next});
        drain_next = 1'b0;
    endtask

    // Appends one random byte sequence, mostly well formed so that the deeper modes get exercised.
    task automatic add_sequence();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        int unsigned j;
        int unsigned digits;
        logic [31:0] cp;
        pick = $urandom_range(0, 99);
        if (pick < 18) begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) add_byte(8'($urandom_range(0, 127)));
        end else if (pick < 33) begin
            case ($urandom_range(1, 3))
                1: begin
                    cp = $urandom_range(32'h80, 32'h7FF);
                    add_byte({3'b110, cp[10:6]});
                    add_byte({2'b10, cp[5:0]});
                end
                2: begin
                    cp = $urandom_range(32'h800, 32'hFFFF);
                    add_byte({4'b1110, cp[15:12]});
                    add_byte({2'b10, cp[11:6]});
                    add_byte({2'b10, cp[5:0]});
                end
                default: begin
                    cp = $urandom_range(32'h10000, 32'h10FFFF);
                    add_byte({5'b11110, cp[20:18]});
                    add_byte({2'b10, cp[17:12]});
                    add_byte({2'b10, cp[11:6]});
                    add_byte({2'b10, cp[5:0]});
                end
            endcase
        end else if (pick < 40) begin
            add_byte(8'($urandom_range(8'hC0, 8'hFF)));
            n = $urandom_range(0, 3);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 1) == 0) add_byte({2'b10, 6'($urandom_range(0, 63))});
                else add_byte(8'($urandom_range(0, 255)));
            end
        end else if (pick < 48) begin
            add_byte(CH_ESC);
            case ($urandom_range(0, 5))
                0:       add_byte(CH_SAVE);
                1:       add_byte(CH_RESTORE);
                2:       add_byte(CH_RIS);
                3:       add_byte(CH_NEL);
                4:       add_byte(CH_IND);
                default: add_byte(CH_RI);
            endcase
        end else if (pick < 53) begin
            add_byte(CH_ESC);
            add_byte(8'($urandom_range(0, 255)));
        end else if (pick < 58) begin
            add_byte(CH_ESC);
            case ($urandom_range(0, 8))
                0:       add_byte(CH_G0);
                1:       add_byte(CH_G1);
                2:       add_byte(CH_G2);
                3:       add_byte(CH_G3);
                4:       add_byte(CH_G1_96);
                5:       add_byte(CH_G2_96);
                6:       add_byte(CH_G3_96);
                7:       add_byte(CH_DEC_LINE);
                default: add_byte(CH_CODING);
            endcase
            add_byte(8'($urandom_range(0, 255)));
        end else if (pick < 65) begin
            add_byte(CH_ESC);
            add_byte(CH_OSC);
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
                if ($urandom_range(0, 7) == 0) begin
                    add_byte(CH_ESC);
                    add_byte(8'($urandom_range(8'h20, 8'h5B)));
                end else begin
                    add_byte(8'($urandom_range(8'h20, 8'h7E)));
                end
            end
            if ($urandom_range(0, 1) == 0) begin
                add_byte(CH_BEL);
            end else begin
                add_byte(CH_ESC);
                add_byte(CH_BACKSLASH);
            end
        end else if (pick < 92) begin
            add_byte(CH_ESC);
            add_byte(CH_CSI);
            if ($urandom_range(0, 3) == 0) add_byte(CH_QMARK);
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 3);
            for (k = 0; k < n; k++) begin
                if (k > 0) add_byte(($urandom_range(0, 3) == 0) ? CH_COLON : CH_SEMI);
                digits = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
                for (j = 0; j < digits; j++) add_byte(CH_DIGIT0 + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 15) == 0) add_byte(CH_GT);
            end
            if ($urandom_range(0, 7) == 0) add_byte(CH_SEMI);
            case ($urandom_range(0, 7))
                0:       add_byte(8'($urandom_range(0, 255)));
                1:       add_byte(CH_QMARK);
                default: add_byte(8'($urandom_range(8'h40, 8'h7E)));
            endcase
        end else begin
            add_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Byte driver: holds each byte until it is taken, idles at random outside a quiet stretch
    // and, where a byte is marked, waits until every pending result has come back.
    always @(posedge aclk) begin
        logic go;
        if (!aresetn) begin
            s_valid   <= 1'b0;
            s_in_byte <= 8'h00;
        end else if (!s_valid || s_ready) begin
            go = byte_queue.size() != 0;
            if (go && byte_queue[0].drain && (s_valid || due_results.size() != 0)) go = 1'b0;
            if (go && !(items_sent >= 120 && items_sent < 180))
                go = $urandom_range(0, 99) >= 33;
            if (go) begin
                s_valid   <= 1'b1;
                s_in_byte <= byte_queue[0].data;
                void'(byte_queue.pop_front());
                items_sent++;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else m_ready <= (results_seen >= 100 && results_seen < 250) || $urandom_range(0, 99) >= 33;
    end

    // Monitor: decodes each accepted byte first, then checks any result taken at the same edge.
    always @(posedge aclk) begin
        parser_result_t got;
        parser_result_t want;
        if (aresetn) begin
            if (s_valid && s_ready) decode_byte(s_in_byte);
            if (m_valid && m_ready) begin
                got = {m_kind, m_value, m_param_index, m_private_mode, m_param_count, m_last};
                results_seen++;
                if (due_results.size() == 0) begin
                    note_error("unexpected result", '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got !== want) note_error("mismatch", want, got);
                end
            end
        end
    end

    initial begin
        int directed_len;
        bit mid_drain_done;
        mid_drain_done = 1'b0;

        // ASCII extremes, an invalid lead byte and a stray continuation byte.
        add_byte(8'h00); add_byte(8'h7F); add_byte(8'hFF); add_byte(8'h80);
        // A broken continuation, after which the byte is taken as plain text.
        add_byte(8'hC3); add_byte(8'h41);
        // An encoded surrogate, then a code point above the Unicode range.
        add_byte(8'hED); add_byte(8'hA0); add_byte(8'h80);
        add_byte(8'hF4); add_byte(8'h90); add_byte(8'h80); add_byte(8'h80);
        // ESC cuts a sequence short, then a full reset clears the decoder.
        add_byte(8'hE2); add_byte(CH_ESC); add_byte(CH_RIS);
        // A private sequence with an ignored byte and a trailing separator.
        add_byte(CH_ESC); add_byte(CH_CSI); add_byte(CH_QMARK); add_byte(CH_GT);
        add_byte(CH_SEMI); add_byte(8'h6D);
        // A final byte with no parameters at all.
        add_byte(CH_ESC); add_byte(CH_CSI); add_byte(8'h41);
        directed_len = byte_queue.size();

        drain_next = 1'b1;
        while (byte_queue.size() < directed_len + RANDOM_ITEMS) begin
            if (!mid_drain_done && byte_queue.size() >= directed_len + RANDOM_ITEMS / 2) begin
                drain_next     = 1'b1;
                mid_drain_done = 1'b1;
            end
            add_sequence();
        end

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        while (byte_queue.size() != 0 || s_valid || due_results.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (fail_count == 0 && due_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tep_pkg.sv
rtl/tep_ram.sv
rtl/tep_dp.sv
rtl/tep_ctrl.sv
rtl/terminal_escape_utf8_parser.sv
test/testbench.sv
